// File: sv/pmit_pkg.sv
// Package with the shared types, constants and operand tables of the inertia tensor block.
`default_nettype none
package pmit_pkg;

   localparam int CRD_W  = 16;   // coordinate port width
   localparam int MASS_W = 16;   // point mass port width
   localparam int CEN_W  = 16;   // centroid result width
   localparam int INR_W  = 53;   // tensor element width
   localparam int ACC_W  = 64;   // moment accumulator width
   localparam int PRD_W  = 128;  // wide product and dividend width
   localparam int CHK_W  = 32;   // multiplier chunk width

   localparam logic [3:0] TERM_SQ_FIRST = 4'd3;
   localparam logic [3:0] TERM_LAST     = 4'd8;
   localparam logic [3:0] JOB_IXX       = 4'd3;
   localparam logic [3:0] JOB_IYY       = 4'd4;
   localparam logic [3:0] JOB_IZZ       = 4'd5;
   localparam logic [3:0] JOB_IXY       = 4'd6;
   localparam logic [3:0] JOB_IXZ       = 4'd7;
   localparam logic [3:0] JOB_IYZ       = 4'd8;
   localparam logic [3:0] JOB_CX        = 4'd0;
   localparam logic [3:0] JOB_CY        = 4'd1;
   localparam logic [3:0] JOB_CZ        = 4'd2;

   localparam logic [1:0] AX_X = 2'd0;
   localparam logic [1:0] AX_Y = 2'd1;
   localparam logic [1:0] AX_Z = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PT_LOAD,
      ST_PT_MUL,
      ST_PT_WAIT,
      ST_END_START,
      ST_END_LOAD,
      ST_END_MUL,
      ST_END_WAIT,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       clear;
      logic       issue;
      logic [1:0] shift;   // chunk offset in units of 32 bits
   } mac_ctl_type;

   function automatic logic [ACC_W-1:0] pmit_mag(input logic [ACC_W-1:0] v);
      return v[ACC_W-1] ? (ACC_W'(0) - v) : v;
   endfunction

   // First operand of a per-point second moment term (index of the m*coord product).
   function automatic logic [1:0] pmit_term_a(input logic [3:0] t);
      case (t)
         4'd3:    return AX_X;
         4'd4:    return AX_Y;
         4'd5:    return AX_Z;
         4'd6:    return AX_X;
         4'd7:    return AX_X;
         4'd8:    return AX_Y;
         default: return t[1:0];
      endcase
   endfunction

   // Coordinate operand of a per-point term.
   function automatic logic [1:0] pmit_term_b(input logic [3:0] t);
      case (t)
         4'd3:    return AX_X;
         4'd4:    return AX_Y;
         4'd5:    return AX_Z;
         4'd6:    return AX_Y;
         4'd7:    return AX_Z;
         4'd8:    return AX_Z;
         default: return t[1:0];
      endcase
   endfunction

   // First moment operands of the wide products of each closing job.
   function automatic logic [1:0] pmit_job_a(input logic [3:0] j, input logic part);
      case (j)
         JOB_IXX: return part ? AX_Z : AX_Y;
         JOB_IYY: return part ? AX_X : AX_Z;
         JOB_IZZ: return part ? AX_Y : AX_X;
         JOB_IXY: return AX_X;
         JOB_IXZ: return AX_X;
         JOB_IYZ: return AX_Y;
         default: return j[1:0];
      endcase
   endfunction

   function automatic logic [1:0] pmit_job_b(input logic [3:0] j, input logic part);
      case (j)
         JOB_IXX: return part ? AX_Z : AX_Y;
         JOB_IYY: return part ? AX_X : AX_Z;
         JOB_IZZ: return part ? AX_Y : AX_X;
         JOB_IXY: return AX_Y;
         JOB_IXZ: return AX_Z;
         JOB_IYZ: return AX_Z;
         default: return j[1:0];
      endcase
   endfunction

endpackage
`default_nettype wire

// File: sv/pmit_mac.sv
// Shared 32x32 multiplier with a registered product and a 128-bit shifted accumulator.
`default_nettype none
module pmit_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  pmit_pkg::mac_ctl_type             ctl,
   input  logic [pmit_pkg::CHK_W-1:0]        op_a,
   input  logic [pmit_pkg::CHK_W-1:0]        op_b,
   output logic [pmit_pkg::PRD_W-1:0]        acc,
   output logic                              pending
);
   import pmit_pkg::*;

   logic [2*CHK_W-1:0] prod_ff;
   logic [1:0]         shift_ff;
   logic               valid_ff;
   logic [PRD_W-1:0]   acc_ff;
   logic [PRD_W-1:0]   addend;

   assign addend  = PRD_W'(prod_ff) << (CHK_W * int'(shift_ff));
   assign acc     = acc_ff;
   assign pending = valid_ff;

   always_ff @(posedge clock) begin
      prod_ff  <= op_a * op_b;
      shift_ff <= ctl.shift;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl.issue;
      end
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (valid_ff) begin
         acc_ff <= acc_ff + addend;
      end
   end

endmodule
`default_nettype wire

// File: sv/pmit_div.sv
// Restoring divider, one quotient bit per cycle, 128-bit dividend and low 64 quotient bits.
`default_nettype none
module pmit_div #(
   parameter int DIV_W = 22
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pmit_pkg::PRD_W-1:0]    dividend,
   input  logic [DIV_W-1:0]              divisor,
   output logic                          done,
   output logic [pmit_pkg::ACC_W-1:0]    quotient
);
   import pmit_pkg::*;

   localparam int CNT_W = $clog2(PRD_W);

   logic [PRD_W-1:0] num_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [ACC_W-1:0] quo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff;
   logic             done_ff;
   logic [DIV_W:0]   rem_sh;
   logic             ge;

   assign rem_sh   = {rem_ff, num_ff[PRD_W-1]};
   assign ge       = rem_sh >= {1'b0, divisor};
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
         quo_ff <= '0;
         cnt_ff <= '0;
      end else if (run_ff) begin
         num_ff <= {num_ff[PRD_W-2:0], 1'b0};
         rem_ff <= ge ? DIV_W'(rem_sh - {1'b0, divisor}) : DIV_W'(rem_sh);
         quo_ff <= {quo_ff[ACC_W-2:0], ge};
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && (cnt_ff == CNT_W'(PRD_W - 1));
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && (cnt_ff == CNT_W'(PRD_W - 1))) begin
            run_ff <= 1'b0;
         end
      end
   end

endmodule
`default_nettype wire

// File: sv/point_mass_inertia_tensor.sv
// Top level: inertia tensor and centroid of a cluster of weighted 3-D points.
//
//   channel   ports                          handshake
//   --------  -----------------------------  ------------------------------------
//   input     req_point_*, req_last_point    taken at a clock edge with start high
//                                            and busy low
//   result    rsp_*                          rsp_valid high for one cycle per item
//
// Each accepted point that is still counted runs nine product terms through the
// single shared 32x32 multiplier, four chunk steps each plus a load and a drain of
// the accumulator. Points beyond MAX_POINTS skip the product terms. A point that
// closes the cluster adds, unless the total mass is zero, nine bit-serial divisions
// of a 128-bit dividend, and the wide squares and cross products of the first
// moments, again through the same multiplier. busy stays high meanwhile.
// Reset is synchronous and clears the sequencer and all sums. The receiver of
// results cannot stall: the result is on the ports for the cycle that rsp_valid
// marks, and stays there until the next cluster starts to close.
`default_nettype none
module point_mass_inertia_tensor #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [pmit_pkg::CRD_W-1:0]       req_point_x,
   input  logic signed [pmit_pkg::CRD_W-1:0]       req_point_y,
   input  logic signed [pmit_pkg::CRD_W-1:0]       req_point_z,
   input  logic        [pmit_pkg::MASS_W-1:0]      req_point_mass,
   input  logic                                    req_last_point,
   output logic                                    rsp_valid,
   output logic signed [pmit_pkg::CEN_W-1:0]       rsp_centroid_x,
   output logic signed [pmit_pkg::CEN_W-1:0]       rsp_centroid_y,
   output logic signed [pmit_pkg::CEN_W-1:0]       rsp_centroid_z,
   output logic        [pmit_pkg::INR_W-1:0]       rsp_inertia_xx,
   output logic        [pmit_pkg::INR_W-1:0]       rsp_inertia_yy,
   output logic        [pmit_pkg::INR_W-1:0]       rsp_inertia_zz,
   output logic signed [pmit_pkg::INR_W-1:0]       rsp_inertia_xy,
   output logic signed [pmit_pkg::INR_W-1:0]       rsp_inertia_xz,
   output logic signed [pmit_pkg::INR_W-1:0]       rsp_inertia_yz,
   output logic                                    rsp_zero_mass_error
);
   import pmit_pkg::*;

   // The total mass is below MAX_POINTS * 2^16, so it fits these bits exactly.
   localparam int TOT_W = MASS_W + $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   // Sign-extends a coordinate from bit COORD_BITS-1 of its zero-extended field.
   function automatic logic [ACC_W-1:0] coord_ext(input logic [CRD_W-1:0] p);
      logic [ACC_W-1:0] raw;
      logic [ACC_W-1:0] v;
      raw = ACC_W'(p);
      for (int i = 0; i < ACC_W; i++) begin
         v[i] = (i < COORD_BITS) ? raw[i] : raw[COORD_BITS-1];
      end
      return v;
   endfunction

   state_type          state_ff, state_in;

   // Sums of the open cluster.
   logic [TOT_W-1:0]   mass_ff;
   logic [ACC_W-1:0]   fm_ff [3];
   logic [ACC_W-1:0]   sm_ff [6];
   logic [CNT_W-1:0]   cnt_ff;

   // The point in work: coordinate magnitudes and signs, mass, the m*coord products.
   logic [CHK_W-1:0]   cmag_ff [3];
   logic [2:0]         cneg_ff;
   logic [MASS_W-1:0]  m_ff;
   logic               last_ff;
   logic [ACC_W-1:0]   pmag_ff [3];
   logic [2:0]         pneg_ff;

   // Sequencer counters and multiplier operands.
   logic [3:0]         term_ff;
   logic [3:0]         job_ff;
   logic               part_ff;
   logic [1:0]         step_ff;
   logic [ACC_W-1:0]   op_a_ff;
   logic [ACC_W-1:0]   op_b_ff;

   // Result registers.
   logic               rsp_valid_ff;
   logic [CEN_W-1:0]   cen_ff [3];
   logic [INR_W-1:0]   inr_ff [6];
   logic               err_ff;

   mac_ctl_type        mac_ctl;
   logic [PRD_W-1:0]   mac_acc;
   logic               mac_pending;
   logic               div_start;
   logic [PRD_W-1:0]   div_dividend;
   logic               div_done;
   logic [ACC_W-1:0]   div_quo;

   logic               accept;
   logic               room;
   logic [ACC_W-1:0]   ext [3];
   logic [ACC_W-1:0]   fmag [3];
   logic [1:0]         ta, tb, ja, jb;
   logic               pt_neg;
   logic [ACC_W-1:0]   pt_val;
   logic [ACC_W-1:0]   pt_sval;
   logic [ACC_W-1:0]   q_signed;
   logic [ACC_W-1:0]   diag_val;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign room   = cnt_ff < CNT_W'(MAX_POINTS);

   assign ext[0] = coord_ext(req_point_x);
   assign ext[1] = coord_ext(req_point_y);
   assign ext[2] = coord_ext(req_point_z);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         fmag[k] = pmit_mag(fm_ff[k]);
      end
   end

   assign ta = pmit_term_a(term_ff);
   assign tb = pmit_term_b(term_ff);
   assign ja = pmit_job_a(job_ff, part_ff);
   assign jb = pmit_job_b(job_ff, part_ff);

   // Signed value of a finished per-point term; its magnitude is below 2^64.
   assign pt_val  = mac_acc[ACC_W-1:0];
   assign pt_neg  = (term_ff < TERM_SQ_FIRST) ? cneg_ff[tb] : (pneg_ff[ta] ^ cneg_ff[tb]);
   assign pt_sval = pt_neg ? (ACC_W'(0) - pt_val) : pt_val;

   // Quotient with the sign of its job: centroid takes the moment's sign, products
   // of two moments the sign of their product.
   always_comb begin
      if (job_ff < JOB_IXX) begin
         q_signed = fm_ff[job_ff[1:0]][ACC_W-1] ? (ACC_W'(0) - div_quo) : div_quo;
      end else begin
         q_signed = (fm_ff[ja][ACC_W-1] ^ fm_ff[jb][ACC_W-1]) ? (ACC_W'(0) - div_quo)
                                                            : div_quo;
      end
   end

   // Parallel-axis form of a diagonal element: two raw second moments less S^2/M.
   always_comb begin
      case (job_ff)
         JOB_IXX: diag_val = sm_ff[1] + sm_ff[2] - div_quo;
         JOB_IYY: diag_val = sm_ff[2] + sm_ff[0] - div_quo;
         default: diag_val = sm_ff[0] + sm_ff[1] - div_quo;
      endcase
   end

   assign div_dividend = (job_ff < JOB_IXX) ? PRD_W'(fmag[job_ff[1:0]]) : mac_acc;

   // Next state and unit controls.
   always_comb begin
      state_in      = state_ff;
      mac_ctl.clear = 1'b0;
      mac_ctl.issue = 1'b0;
      mac_ctl.shift = 2'(step_ff[1]) + 2'(step_ff[0]);
      div_start     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (room) begin
                  state_in = ST_PT_LOAD;
               end else if (req_last_point) begin
                  state_in = ST_END_START;
               end
            end
         end
         ST_PT_LOAD: begin
            mac_ctl.clear = 1'b1;
            state_in      = ST_PT_MUL;
         end
         ST_PT_MUL: begin
            mac_ctl.issue = 1'b1;
            if (step_ff == 2'd3) begin
               state_in = ST_PT_WAIT;
            end
         end
         ST_PT_WAIT: begin
            if (!mac_pending) begin
               if (term_ff != TERM_LAST) begin
                  state_in = ST_PT_LOAD;
               end else if (last_ff) begin
                  state_in = ST_END_START;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_END_START: begin
            state_in = (mass_ff == '0) ? ST_FINISH : ST_END_LOAD;
         end
         ST_END_LOAD: begin
            // Centroid jobs divide a first moment straight away.
            if (job_ff < JOB_IXX) begin
               state_in = ST_DIV_GO;
            end else begin
               mac_ctl.clear = !part_ff;
               state_in      = ST_END_MUL;
            end
         end
         ST_END_MUL: begin
            mac_ctl.issue = 1'b1;
            if (step_ff == 2'd3) begin
               state_in = ST_END_WAIT;
            end
         end
         ST_END_WAIT: begin
            if (!mac_pending) begin
               // Diagonal jobs sum two squares in the accumulator before dividing.
               state_in = (job_ff < JOB_IXY && !part_ff) ? ST_END_LOAD : ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = (job_ff == JOB_IYZ) ? ST_FINISH : ST_END_LOAD;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers, sums and sequencer counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            fm_ff[k] <= '0;
         end
         for (int k = 0; k < 6; k++) begin
            sm_ff[k] <= '0;
         end
      end else begin
         rsp_valid_ff <= (state_ff == ST_FINISH);
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  m_ff    <= req_point_mass;
                  last_ff <= req_last_point;
                  term_ff <= '0;
                  for (int k = 0; k < 3; k++) begin
                     cmag_ff[k] <= CHK_W'(pmit_mag(ext[k]));
                     cneg_ff[k] <= ext[k][ACC_W-1];
                  end
                  if (room) begin
                     mass_ff <= mass_ff + TOT_W'(req_point_mass);
                     cnt_ff  <= cnt_ff + 1'b1;
                  end
               end
            end
            ST_PT_LOAD: begin
               step_ff <= '0;
               if (term_ff < TERM_SQ_FIRST) begin
                  op_a_ff <= ACC_W'(m_ff);
               end else begin
                  op_a_ff <= pmag_ff[ta];
               end
               op_b_ff <= ACC_W'(cmag_ff[tb]);
            end
            ST_PT_MUL, ST_END_MUL: begin
               step_ff <= step_ff + 1'b1;
            end
            ST_PT_WAIT: begin
               if (!mac_pending) begin
                  term_ff <= term_ff + 1'b1;
                  if (term_ff < TERM_SQ_FIRST) begin
                     pmag_ff[tb] <= pt_val;
                     pneg_ff[tb] <= cneg_ff[tb];
                     fm_ff[tb]   <= fm_ff[tb] + pt_sval;
                  end else begin
                     sm_ff[3'(term_ff - TERM_SQ_FIRST)] <=
                        sm_ff[3'(term_ff - TERM_SQ_FIRST)] + pt_sval;
                  end
               end
            end
            ST_END_START: begin
               job_ff  <= JOB_CX;
               part_ff <= 1'b0;
               err_ff  <= (mass_ff == '0);
               for (int k = 0; k < 3; k++) begin
                  cen_ff[k] <= '0;
               end
               for (int k = 0; k < 6; k++) begin
                  inr_ff[k] <= '0;
               end
            end
            ST_END_LOAD: begin
               step_ff <= '0;
               op_a_ff <= fmag[ja];
               op_b_ff <= fmag[jb];
            end
            ST_END_WAIT: begin
               if (!mac_pending && job_ff < JOB_IXY && !part_ff) begin
                  part_ff <= 1'b1;
               end
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  job_ff  <= job_ff + 1'b1;
                  part_ff <= 1'b0;
                  if (job_ff < JOB_IXX) begin
                     cen_ff[job_ff[1:0]] <= q_signed[CEN_W-1:0];
                  end else if (job_ff < JOB_IXY) begin
                     inr_ff[3'(job_ff - JOB_IXX)] <= diag_val[INR_W-1:0];
                  end else begin
                     inr_ff[3'(job_ff - JOB_IXX)] <=
                        INR_W'(q_signed - sm_ff[3'(job_ff - JOB_IXX)]);
                  end
               end
            end
            ST_FINISH: begin
               // The cluster is closed: clear all sums for the next one.
               mass_ff <= '0;
               cnt_ff  <= '0;
               for (int k = 0; k < 3; k++) begin
                  fm_ff[k] <= '0;
               end
               for (int k = 0; k < 6; k++) begin
                  sm_ff[k] <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   pmit_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .op_a    (step_ff[1] ? op_a_ff[2*CHK_W-1:CHK_W] : op_a_ff[CHK_W-1:0]),
      .op_b    (step_ff[0] ? op_b_ff[2*CHK_W-1:CHK_W] : op_b_ff[CHK_W-1:0]),
      .acc     (mac_acc),
      .pending (mac_pending)
   );

   pmit_div #(
      .DIV_W (TOT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (mass_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_centroid_x      = cen_ff[0];
   assign rsp_centroid_y      = cen_ff[1];
   assign rsp_centroid_z      = cen_ff[2];
   assign rsp_inertia_xx      = inr_ff[0];
   assign rsp_inertia_yy      = inr_ff[1];
   assign rsp_inertia_zz      = inr_ff[2];
   assign rsp_inertia_xy      = inr_ff[3];
   assign rsp_inertia_xz      = inr_ff[4];
   assign rsp_inertia_yz      = inr_ff[5];
   assign rsp_zero_mass_error = err_ff;

endmodule
`default_nettype wire
